// ===== sv/dwsc_pkg.sv =====
`timescale 1ns / 1ps
package dwsc_pkg;

  localparam int MAX_DELAY_DEF = 1024;
  localparam int SAMPLE_W_DEF  = 24;

  localparam int COEF_W    = 16;
  localparam int GAIN_W    = 17;
  localparam int DLEN_W    = 11;
  localparam int FRAC_BITS = 16;
  localparam int COEF_BITS = 14;
  localparam int COEF_ONE  = 16384;
  localparam int QUOT_W    = 16;
  localparam int CNT_W     = 4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_END_B     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_LEN = 2'd1;

  localparam logic FUNC_POP  = 1'b0;
  localparam logic FUNC_PUSH = 1'b1;

  localparam logic [DLEN_W-1:0] DLEN_RESET = 11'd1024;

  typedef enum logic [12:0] {
    S_CLR  = 13'b0000000000001,
    S_IDLE = 13'b0000000000010,
    S_MOD  = 13'b0000000000100,
    S_RD   = 13'b0000000001000,
    S_CB   = 13'b0000000010000,
    S_CF   = 13'b0000000100000,
    S_DIV  = 13'b0000001000000,
    S_FIX  = 13'b0000010000000,
    S_MULA = 13'b0000100000000,
    S_MULB = 13'b0001000000000,
    S_MULW = 13'b0010000000000,
    S_OUT  = 13'b0100000000000,
    S_WR   = 13'b1000000000000
  } state_t;

endpackage

// ===== sv/dwsc_ram.sv =====
`timescale 1ns / 1ps
module dwsc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/dwsc_step.sv =====
`timescale 1ns / 1ps
module dwsc_step #(
  parameter int DW = 26
) (
  input  logic [DW-1:0] rem_in,
  input  logic [DW-1:0] divisor,
  input  logic          bit_in,
  output logic [DW-1:0] rem_out,
  output logic          q_bit
);

  // one restoring shift-subtract step
  logic [DW:0] trial;
  logic [DW:0] diff;

  always_comb begin
    trial = {rem_in, bit_in};
    diff  = trial - {1'b0, divisor};
    q_bit = (trial >= {1'b0, divisor});
    rem_out = q_bit ? diff[DW-1:0] : trial[DW-1:0];
  end

endmodule

// ===== sv/dwsc_mac.sv =====
`timescale 1ns / 1ps
module dwsc_mac
  import dwsc_pkg::*;
#(
  parameter int SW = SAMPLE_W_DEF
) (
  input  logic                     clk,
  input  logic                     load,
  input  logic signed [SW-1:0]     a,
  input  logic signed [GAIN_W-1:0] b,
  input  logic signed [SW-1:0]     c,
  output logic signed [SW-1:0]     y
);

  localparam int PW = SW + GAIN_W;
  localparam int TW = PW + 2;
  localparam logic signed [TW-1:0] SMAX = {{(TW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [TW-1:0] SMIN = ~SMAX;
  localparam logic signed [TW-1:0] HALF = TW'(1 << (COEF_BITS-1));

  logic signed [PW-1:0] prod_r;
  logic signed [SW-1:0] add_r;
  logic signed [TW-1:0] rnd;
  logic signed [TW-1:0] sum;

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= a * b;
      add_r  <= c;
    end
  end

  // round half up at bit 14, add, saturate
  always_comb begin
    rnd = (TW'(prod_r) + HALF) >>> COEF_BITS;
    sum = rnd + TW'(add_r);
    if (sum > SMAX) begin
      y = SMAX[SW-1:0];
    end else if (sum < SMIN) begin
      y = SMIN[SW-1:0];
    end else begin
      y = sum[SW-1:0];
    end
  end

endmodule

// ===== sv/dual_delay_waveguide_soft_clip.sv =====
`timescale 1ns / 1ps
// channel | direction | handshake            | payload
// cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
// in      | in        | in_valid/in_ready    | in_func, in_end_a_reflection, in_forward_in,
//         |           |                      | in_backward_in
// out     | out       | out_valid/out_ready  | out_out_at_a, out_out_at_b, out_clipped
//
// after reset a clearing pass zeroes both lines, no item taken
// push item: position modulo, two products, write
// pop item: modulo, line read, clip each sample (divide if clipped), two products, output
// the shared shift-subtract step gives one modulo bit or quotient bit a cycle
// a finished result waits in the output register; the next item is taken meanwhile
module dual_delay_waveguide_soft_clip
  import dwsc_pkg::*;
#(
  parameter int MAX_DELAY    = MAX_DELAY_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_W_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_func,
  input  logic signed [COEF_W-1:0]       in_end_a_reflection,
  input  logic signed [SAMPLE_WIDTH-1:0] in_forward_in,
  input  logic signed [SAMPLE_WIDTH-1:0] in_backward_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] out_out_at_a,
  output logic signed [SAMPLE_WIDTH-1:0] out_out_at_b,
  output logic                           out_clipped
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int PW = $clog2(MAX_DELAY);
  localparam int LW = PW + 1;
  // step width covers the clip divisor and the length
  localparam int DW = (SW + 2 > 23) ? SW + 2 : 23;
  localparam logic [DW-1:0] CLIP_LIM = DW'(20 << FRAC_BITS);
  localparam logic [DW-1:0] CLIP_ONE = DW'(1 << FRAC_BITS);
  localparam logic [DW-1:0] CLIP_TOP = DW'(21 << FRAC_BITS);
  localparam logic [PW-1:0] CLR_LAST = PW'(MAX_DELAY - 1);

  state_t state_r, state_nxt;

  // configuration
  logic signed [COEF_W-1:0] endb_r;
  logic [DLEN_W-1:0]        dlen_r;
  logic [LW-1:0]            len_use;

  // item and line state
  logic                     func_r, func_nxt;
  logic signed [COEF_W-1:0] alpha_r, alpha_nxt;
  logic signed [SW-1:0]     fin_r, fin_nxt, bin_r, bin_nxt;
  logic [PW-1:0]            wp_r, wp_nxt;
  logic [PW-1:0]            addr_r, addr_nxt;
  logic [PW-1:0]            clr_r, clr_nxt;
  logic signed [SW-1:0]     kb_r, kb_nxt, kf_r, kf_nxt;

  // sequencer working registers
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DW-1:0]     rem_r, rem_nxt, div_r, div_nxt;
  logic [PW-1:0]     wpsh_r, wpsh_nxt;
  logic [QUOT_W-1:0] q_r, q_nxt;
  logic              neg_r, neg_nxt, sel_r, sel_nxt, hit_r, hit_nxt;
  logic signed [SW-1:0] res_a_r, res_a_nxt, res_b_r, res_b_nxt;

  // output register
  logic                 oval_r, oval_nxt;
  logic signed [SW-1:0] oa_r, oa_nxt, ob_r, ob_nxt;
  logic                 oc_r, oc_nxt;

  // shared step unit
  logic [DW-1:0] st_rem;
  logic          st_bit_in, st_q;

  // line memories
  logic          ram_we;
  logic [PW-1:0] ram_waddr;
  logic [SW-1:0] fwd_wdata, bwd_wdata, fwd_q, bwd_q;

  // clip front end
  logic signed [SW-1:0] clip_src;
  logic signed [SW:0]   clip_ext;
  logic [DW-1:0]        clip_mag;
  logic [DW-1:0]        clip_v;
  logic [DW-1:0]        clip_kv;

  // multiplier operands
  logic                     mac_load;
  logic signed [SW-1:0]     mac_a, mac_c, mac_y;
  logic signed [GAIN_W-1:0] mac_b, alpha_x, beta_x, gain_a, gain_b;

  logic [LW-1:0] pos_inc;
  logic [PW-1:0] pos_wrap;

  assign cfg_ready    = 1'b1;
  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = oval_r;
  assign out_out_at_a = oa_r;
  assign out_out_at_b = ob_r;
  assign out_clipped  = oc_r;

  // zero means one, beyond the memory means the memory
  always_comb begin
    if (dlen_r == '0) begin
      len_use = LW'(1);
    end else if (int'(dlen_r) > MAX_DELAY) begin
      len_use = LW'(MAX_DELAY);
    end else begin
      len_use = LW'(dlen_r);
    end
  end

  // gains 1 - |c| in Q2.14
  always_comb begin
    alpha_x = GAIN_W'(alpha_r);
    beta_x  = GAIN_W'(endb_r);
    gain_a  = GAIN_W'(COEF_ONE) - (alpha_x < 0 ? -alpha_x : alpha_x);
    gain_b  = GAIN_W'(COEF_ONE) - (beta_x < 0 ? -beta_x : beta_x);
  end

  // next position after the reduced one from the modulo result
  always_comb begin
    pos_inc  = {1'b0, st_rem[PW-1:0]} + LW'(1);
    pos_wrap = (pos_inc == len_use) ? '0 : pos_inc[PW-1:0];
  end

  always_comb begin
    clip_src = (state_r == S_CF) ? signed'(fwd_q) : signed'(bwd_q);
    clip_ext = {clip_src[SW-1], clip_src};
    clip_mag = (clip_ext < 0) ? DW'(-clip_ext) : DW'(clip_ext);
    clip_v   = CLIP_TOP - DW'(q_r);
    clip_kv  = neg_r ? -clip_v : clip_v;
  end

  assign st_bit_in = (state_r == S_MOD) ? wpsh_r[PW-1] : 1'b0;

  dwsc_step #(.DW(DW)) u_step (
    .rem_in  (rem_r),
    .divisor (div_r),
    .bit_in  (st_bit_in),
    .rem_out (st_rem),
    .q_bit   (st_q)
  );

  // first product uses the backward sample, second the forward one
  always_comb begin
    mac_load = (state_r == S_MULA) || (state_r == S_MULB);
    if (state_r == S_MULA) begin
      mac_a = kb_r;
      mac_b = (func_r == FUNC_PUSH) ? alpha_x : gain_a;
      mac_c = (func_r == FUNC_PUSH) ? fin_r : '0;
    end else begin
      mac_a = kf_r;
      mac_b = (func_r == FUNC_PUSH) ? beta_x : gain_b;
      mac_c = (func_r == FUNC_PUSH) ? bin_r : '0;
    end
  end

  dwsc_mac #(.SW(SW)) u_mac (
    .clk  (clk),
    .load (mac_load),
    .a    (mac_a),
    .b    (mac_b),
    .c    (mac_c),
    .y    (mac_y)
  );

  always_comb begin
    ram_we    = (state_r == S_CLR) || (state_r == S_WR);
    ram_waddr = (state_r == S_CLR) ? clr_r : addr_r;
    fwd_wdata = (state_r == S_CLR) ? '0 : res_a_r;
    bwd_wdata = (state_r == S_CLR) ? '0 : res_b_r;
  end

  dwsc_ram #(.WIDTH(SW), .DEPTH(MAX_DELAY)) u_fwd_line (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (fwd_wdata),
    .rd_addr (addr_r),
    .rd_data (fwd_q)
  );

  dwsc_ram #(.WIDTH(SW), .DEPTH(MAX_DELAY)) u_bwd_line (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (bwd_wdata),
    .rd_addr (addr_r),
    .rd_data (bwd_q)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    func_nxt  = func_r;
    alpha_nxt = alpha_r;
    fin_nxt   = fin_r;
    bin_nxt   = bin_r;
    wp_nxt    = wp_r;
    addr_nxt  = addr_r;
    clr_nxt   = clr_r;
    kb_nxt    = kb_r;
    kf_nxt    = kf_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    wpsh_nxt  = wpsh_r;
    q_nxt     = q_r;
    neg_nxt   = neg_r;
    sel_nxt   = sel_r;
    hit_nxt   = hit_r;
    res_a_nxt = res_a_r;
    res_b_nxt = res_b_r;
    oval_nxt  = (oval_r && out_ready) ? 1'b0 : oval_r;
    oa_nxt    = oa_r;
    ob_nxt    = ob_r;
    oc_nxt    = oc_r;

    unique case (state_r)
      S_CLR: begin
        clr_nxt = clr_r + PW'(1);
        if (clr_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          func_nxt  = in_func;
          alpha_nxt = in_end_a_reflection;
          fin_nxt   = in_forward_in;
          bin_nxt   = in_backward_in;
          rem_nxt   = '0;
          div_nxt   = DW'(len_use);
          wpsh_nxt  = wp_r;
          cnt_nxt   = CNT_W'(PW - 1);
          hit_nxt   = 1'b0;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        // write position reduced modulo the length in use, one bit a cycle
        rem_nxt  = st_rem;
        wpsh_nxt = wpsh_r << 1;
        cnt_nxt  = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          if (func_r == FUNC_PUSH) begin
            addr_nxt  = st_rem[PW-1:0];
            state_nxt = S_MULA;
          end else begin
            addr_nxt  = pos_wrap;
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        state_nxt = S_CB;
      end
      S_CB, S_CF: begin
        sel_nxt = (state_r == S_CF);
        if (clip_mag > CLIP_LIM) begin
          rem_nxt   = CLIP_ONE;
          div_nxt   = clip_mag - CLIP_LIM + CLIP_ONE;
          q_nxt     = '0;
          cnt_nxt   = CNT_W'(QUOT_W - 1);
          neg_nxt   = clip_src[SW-1];
          state_nxt = S_DIV;
        end else if (state_r == S_CB) begin
          kb_nxt    = clip_src;
          state_nxt = S_CF;
        end else begin
          kf_nxt    = clip_src;
          state_nxt = S_MULA;
        end
      end
      S_DIV: begin
        // 2^32 / d, one quotient bit a cycle
        rem_nxt = st_rem;
        q_nxt   = {q_r[QUOT_W-2:0], st_q};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        hit_nxt = 1'b1;
        if (!sel_r) begin
          kb_nxt    = signed'(clip_kv[SW-1:0]);
          state_nxt = S_CF;
        end else begin
          kf_nxt    = signed'(clip_kv[SW-1:0]);
          state_nxt = S_MULA;
        end
      end
      S_MULA: begin
        state_nxt = S_MULB;
      end
      S_MULB: begin
        res_a_nxt = mac_y;
        state_nxt = S_MULW;
      end
      S_MULW: begin
        res_b_nxt = mac_y;
        state_nxt = (func_r == FUNC_PUSH) ? S_WR : S_OUT;
      end
      S_OUT: begin
        if (!oval_r || out_ready) begin
          oval_nxt  = 1'b1;
          oa_nxt    = res_a_r;
          ob_nxt    = res_b_r;
          oc_nxt    = hit_r;
          state_nxt = S_IDLE;
        end
      end
      S_WR: begin
        wp_nxt    = ({1'b0, addr_r} + LW'(1) == len_use) ? '0 : addr_r + PW'(1);
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      wp_r    <= '0;
      kb_r    <= '0;
      kf_r    <= '0;
      oval_r  <= 1'b0;
      endb_r  <= '0;
      dlen_r  <= DLEN_RESET;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      wp_r    <= wp_nxt;
      kb_r    <= kb_nxt;
      kf_r    <= kf_nxt;
      oval_r  <= oval_nxt;
      if (cfg_valid) begin
        if (cfg_index == CFG_END_B) begin
          endb_r <= signed'(cfg_data[COEF_W-1:0]);
        end else if (cfg_index == CFG_DELAY_LEN) begin
          dlen_r <= cfg_data[DLEN_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    func_r  <= func_nxt;
    alpha_r <= alpha_nxt;
    fin_r   <= fin_nxt;
    bin_r   <= bin_nxt;
    addr_r  <= addr_nxt;
    cnt_r   <= cnt_nxt;
    rem_r   <= rem_nxt;
    div_r   <= div_nxt;
    wpsh_r  <= wpsh_nxt;
    q_r     <= q_nxt;
    neg_r   <= neg_nxt;
    sel_r   <= sel_nxt;
    hit_r   <= hit_nxt;
    res_a_r <= res_a_nxt;
    res_b_r <= res_b_nxt;
    oa_r    <= oa_nxt;
    ob_r    <= ob_nxt;
    oc_r    <= oc_nxt;
  end

  // modulo result lands below the length
  a_mod_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOD && cnt_r == '0) |=> ({1'b0, addr_r} < $past(len_use)))
    else $error("reduced position not below length");

  // a push leaves the position below the length
  a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR) |=> ({1'b0, wp_r} < $past(len_use)))
    else $error("write position out of range");

  // a result only appears from the output state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(oval_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside output state");

  // no item taken during the clearing pass
  a_clr_block: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> !in_ready)
    else $error("item taken while clearing");

endmodule

// ===== tb/tb_dual_delay_waveguide_soft_clip.sv =====
`timescale 1ns / 1ps
module tb_dual_delay_waveguide_soft_clip;
  import dwsc_pkg::*;

  localparam int SW        = SAMPLE_W_DEF;
  localparam int LINE_LEN  = MAX_DELAY_DEF;
  localparam int SETTLE    = 150;
  localparam int HOLD_LEN  = 400;
  localparam longint SMAX  = (64'sd1 <<< (SW - 1)) - 1;
  localparam longint SMIN  = -(64'sd1 <<< (SW - 1));
  localparam longint ONE_Q = 64'sd1 <<< FRAC_BITS;
  localparam longint CLIP_LIM = 20 * ONE_Q;

  typedef struct packed {
    logic signed [SW-1:0] at_a;
    logic signed [SW-1:0] at_b;
    logic                 clip;
  } wg_out_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_func;
  logic signed [COEF_W-1:0] in_end_a_reflection;
  logic signed [SW-1:0]  in_forward_in;
  logic signed [SW-1:0]  in_backward_in;
  logic                  out_valid;
  logic                  out_ready;
  logic signed [SW-1:0]  out_out_at_a;
  logic signed [SW-1:0]  out_out_at_b;
  logic                  out_clipped;

  // shadow copy of the waveguide state
  longint fwd_line [LINE_LEN];
  longint bwd_line [LINE_LEN];
  int     wr_pos;
  longint kept_fwd;
  longint kept_bwd;
  logic [COEF_W-1:0] end_b_coef;
  logic [DLEN_W-1:0] line_len_reg;

  wg_out_t pending_outs[$];
  int      mismatches;
  bit      steady_flow;   // no random idling on either side
  bit      hold_req;      // ask the receiver for a long hold-off

  dual_delay_waveguide_soft_clip i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_func             (in_func),
    .in_end_a_reflection (in_end_a_reflection),
    .in_forward_in       (in_forward_in),
    .in_backward_in      (in_backward_in),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_out_at_a        (out_out_at_a),
    .out_out_at_b        (out_out_at_b),
    .out_clipped         (out_clipped)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // generous ceiling, well above the slowest legal run
  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  // ---------------- predictor ----------------

  function automatic longint sat_sample(input longint x);
    if (x > SMAX) return SMAX;
    if (x < SMIN) return SMIN;
    return x;
  endfunction

  // q14 product back to q16, half rounds upward (arithmetic shift floors)
  function automatic longint q14_round(input longint x);
    return (x + (64'sd1 <<< (COEF_BITS - 1))) >>> COEF_BITS;
  endfunction

  function automatic longint soft_limit(input longint s, output bit hit);
    longint mag;
    longint lim_v;
    mag = (s < 0) ? -s : s;
    hit = (mag > CLIP_LIM);
    if (!hit) return s;
    lim_v = CLIP_LIM + ONE_Q - ((64'sd1 <<< (2 * FRAC_BITS)) / (mag - CLIP_LIM + ONE_Q));
    return (s < 0) ? -lim_v : lim_v;
  endfunction

  function automatic longint end_loss(input longint v, input longint coef);
    longint gain;
    gain = COEF_ONE - ((coef < 0) ? -coef : coef);
    return sat_sample(q14_round(v * gain));
  endfunction

  function automatic int used_len();
    if (line_len_reg == 0) return 1;
    if (line_len_reg > LINE_LEN) return LINE_LEN;
    return int'(line_len_reg);
  endfunction

  task automatic waveguide_step(input logic func, input logic signed [COEF_W-1:0] alpha,
                                input logic signed [SW-1:0] fin,
                                input logic signed [SW-1:0] bin);
    int      len;
    int      idx;
    bit      hit_b;
    bit      hit_f;
    longint  a;
    longint  beta;
    wg_out_t res;
    len  = used_len();
    a    = longint'(alpha);
    beta = longint'($signed(end_b_coef));
    if (func == FUNC_POP) begin
      idx      = (wr_pos + 1) % len;
      kept_bwd = soft_limit(bwd_line[idx], hit_b);
      kept_fwd = soft_limit(fwd_line[idx], hit_f);
      res.at_a = SW'(end_loss(kept_bwd, a));
      res.at_b = SW'(end_loss(kept_fwd, beta));
      res.clip = hit_b | hit_f;
      pending_outs.push_back(res);
    end else begin
      idx = wr_pos % len;
      fwd_line[idx] = sat_sample(q14_round(kept_bwd * a) + longint'(fin));
      bwd_line[idx] = sat_sample(q14_round(kept_fwd * beta) + longint'(bin));
      wr_pos = (wr_pos + 1) % len;
    end
  endtask

  // ---------------- result checker ----------------

  always @(posedge clk) begin
    wg_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_outs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result a=%0d b=%0d clip=%0b",
                   out_out_at_a, out_out_at_b, out_clipped);
      end else begin
        want = pending_outs.pop_front();
        if (want.at_a !== out_out_at_a || want.at_b !== out_out_at_b ||
            want.clip !== out_clipped) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected a=%0d b=%0d clip=%0b, got a=%0d b=%0d clip=%0b",
                     want.at_a, want.at_b, want.clip,
                     out_out_at_a, out_out_at_b, out_clipped);
        end
      end
    end
  end

  // receiver: random stalls, plus a long counted hold-off on request
  initial begin
    int hold_cnt;
    hold_cnt  = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_cnt = HOLD_LEN;
        hold_req = 1'b0;
      end
      if (hold_cnt > 0) begin
        out_ready = 1'b0;
        hold_cnt--;
      end else if (steady_flow) begin
        out_ready = 1'b1;
      end else begin
        out_ready = ($urandom_range(99) >= 18);
      end
    end
  end

  // ---------------- drivers ----------------

  // called just after a falling edge; returns just after a falling edge with valid still up
  task automatic send_item(input logic func, input logic signed [COEF_W-1:0] alpha,
                           input logic signed [SW-1:0] fin,
                           input logic signed [SW-1:0] bin);
    if (!steady_flow && $urandom_range(99) < 18) begin
      in_valid = 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    in_valid            = 1'b1;
    in_func             = func;
    in_end_a_reflection = alpha;
    in_forward_in       = fin;
    in_backward_in      = bin;
    forever begin
      @(posedge clk);
      if (in_ready) break;
      @(negedge clk);
    end
    waveguide_step(func, alpha, fin, bin);
    @(negedge clk);
  endtask

  // sender pause: wait for every pending result, then let trailing pushes finish
  task automatic drain();
    in_valid = 1'b0;
    while (pending_outs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
      @(negedge clk);
    end
    if (idx == CFG_END_B) end_b_coef = val;
    else if (idx == CFG_DELAY_LEN) line_len_reg = val[DLEN_W-1:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // ---------------- random content ----------------

  function automatic logic signed [SW-1:0] rand_sample();
    int     pick;
    longint mag;
    pick = $urandom_range(9);
    if (pick < 4) return SW'($urandom);
    if (pick < 7) begin
      // near the clipping knee on either side
      mag = CLIP_LIM + $signed($urandom_range(32'(4 * ONE_Q))) - 2 * ONE_Q;
      return SW'($urandom_range(1) ? mag : -mag);
    end
    if (pick == 7) return $urandom_range(1) ? SW'(SMAX) : SW'(SMIN);
    return SW'($signed($urandom_range(32'(2 * ONE_Q))) - ONE_Q);
  endfunction

  function automatic logic signed [COEF_W-1:0] rand_coef();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return COEF_W'($urandom);
    if (pick == 1) begin
      case ($urandom_range(3))
        0: return 16'sh7fff;
        1: return 16'sh8000;
        2: return 16'sd16384;
        default: return -16'sd16384;
      endcase
    end
    return COEF_W'($signed($urandom_range(2 * COEF_ONE)) - COEF_ONE);
  endfunction

  task automatic random_burst(input int n_items, input int push_pct);
    repeat (n_items) begin
      if ($urandom_range(99) < push_pct)
        send_item(FUNC_PUSH, rand_coef(), rand_sample(), rand_sample());
      else
        send_item(FUNC_POP, rand_coef(), rand_sample(), rand_sample());
    end
  endtask

  // ---------------- tests ----------------

  // lines come out of reset empty, full length in use
  task automatic test_after_reset();
    send_item(FUNC_POP, 16'sd0, '0, '0);
    send_item(FUNC_PUSH, 16'sd8192, 24'sd65536, -24'sd65536);
    send_item(FUNC_POP, 16'sh8000, '0, '0);
    drain();
  endtask

  // field extremes, every coefficient corner and the clipping knee
  task automatic test_extremes();
    write_reg(CFG_DELAY_LEN, 16'd3);
    write_reg(CFG_END_B, 16'h8000);
    send_item(FUNC_PUSH, 16'sh7fff, SW'(SMAX), SW'(SMIN));
    send_item(FUNC_PUSH, 16'sh8000, SW'(CLIP_LIM), SW'(CLIP_LIM + 1));
    send_item(FUNC_PUSH, -16'sd16384, SW'(-CLIP_LIM - 1), SW'(-CLIP_LIM));
    send_item(FUNC_POP, 16'sd16384, '0, '0);
    send_item(FUNC_POP, 16'sd0, '0, '0);
    send_item(FUNC_PUSH, 16'sh7fff, 24'sd1, -24'sd1);
    send_item(FUNC_POP, 16'sh8000, '0, '0);
    send_item(FUNC_PUSH, 16'sh8000, SW'(SMIN), SW'(SMAX));
    send_item(FUNC_POP, -16'sd16384, 24'sh5a5a5a, 24'sha5a5a5);
    send_item(FUNC_PUSH, 16'sd0, '0, '0);
    send_item(FUNC_POP, 16'sh7fff, '0, '0);
    drain();
    write_reg(CFG_END_B, 16'h7fff);
    send_item(FUNC_PUSH, 16'sd16384, SW'(SMAX), SW'(SMAX));
    send_item(FUNC_POP, 16'sd1, '0, '0);
    send_item(FUNC_POP, 16'sh8000, '0, '0);
    send_item(FUNC_PUSH, -16'sd1, 24'sh7fffff, 24'sh800000);
    send_item(FUNC_POP, 16'sh4000, '0, '0);
    drain();
  endtask

  // zero and oversized lengths, shrinking mid-stream, unmapped indexes
  task automatic test_length_edges();
    write_reg(CFG_DELAY_LEN, 16'd0);
    send_item(FUNC_PUSH, 16'sd4000, 24'sd300000, -24'sd300000);
    send_item(FUNC_POP, 16'sd4000, '0, '0);
    drain();
    write_reg(CFG_DELAY_LEN, 16'hffff);   // masked to 2047, used as full depth
    random_burst(6, 60);
    drain();
    write_reg(CFG_DELAY_LEN, 16'd9);
    random_burst(14, 70);
    drain();
    // shrink with the position beyond the new length
    write_reg(CFG_DELAY_LEN, 16'd2);
    random_burst(6, 50);
    drain();
    write_reg(2'd2, 16'hffff);
    write_reg(2'd3, 16'h0001);
    random_burst(4, 50);
    drain();
  endtask

  // long receiver hold-off while items keep coming, then a steady stretch
  task automatic test_backpressure();
    write_reg(CFG_END_B, 16'sd9000);
    write_reg(CFG_DELAY_LEN, 16'd4);
    hold_req = 1'b1;
    random_burst(30, 30);
    drain();
    steady_flow = 1'b1;
    random_burst(120, 50);
    drain();
    steady_flow = 1'b0;
  endtask

  task automatic test_random();
    logic [15:0] coefs [7];
    logic [15:0] lens  [7];
    int          counts [7];
    coefs = '{16'd0, 16'd16384, 16'hc000, 16'h7fff, 16'h8000, 16'd5000, 16'he4a8};
    lens  = '{16'd1, 16'd2, 16'd5, 16'd16, 16'd3, 16'd1024, 16'd7};
    counts = '{110, 110, 120, 120, 110, 60, 120};
    for (int k = 0; k < 7; k++) begin
      write_reg(CFG_END_B, coefs[k]);
      write_reg(CFG_DELAY_LEN, lens[k]);
      random_burst(counts[k], 55);
      drain();
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    in_func     = FUNC_POP;
    in_end_a_reflection = '0;
    in_forward_in  = '0;
    in_backward_in = '0;
    mismatches  = 0;
    steady_flow = 1'b0;
    hold_req    = 1'b0;
    for (int i = 0; i < LINE_LEN; i++) begin
      fwd_line[i] = 0;
      bwd_line[i] = 0;
    end
    wr_pos       = 0;
    kept_fwd     = 0;
    kept_bwd     = 0;
    end_b_coef   = '0;
    line_len_reg = DLEN_RESET;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_after_reset();
    test_extremes();
    test_length_edges();
    test_backpressure();
    test_random();

    if (mismatches == 0 && pending_outs.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
